/* src/ucfp_pkg.sv */
// ----------------------------------------------------------------------------
// ucfp_pkg
// Shared types and constants for the command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CMD_W     = 16;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_SPEED_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SPEED_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_POWER_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_POWER_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(FRAME_LEN - 2);

  // register reset values
  localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RST   = 8'h55;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEADER = 2'd0,
    REG_TAIL   = 2'd1
  } cfg_reg_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_SUM  = 2'd2
  } frame_status_t;

  // result tdata width: speed, power, clear, stop, padded to bytes
  localparam int unsigned OUT_DATA_W = 40;

endpackage

/* src/uart_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// uart_command_frame_parser
// Hunts for a header byte, collects a nine-byte command frame, checks tail
// and checksum and reports one status request per frame.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle. While hunting, bytes other than the
// header are dropped. A header opens a nine-byte frame (header, speed hi/lo,
// power hi/lo, two reserved, checksum, tail); the checksum is the low byte of
// the sum of the first seven bytes. In the cycle after the tail byte is taken, a
// result request appears on the out_ channel: status in out_tuser, commands in
// out_tdata, zeroed unless the frame is good. The result sits in a single
// output register; a byte is taken in any cycle in which that register is
// empty or being drained, so with out_tready high the rate is one byte per
// cycle. No other byte produces a result.
module uart_command_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream; tdata: rx_byte[7:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  // result stream; tdata: speed_command[15:0], power_limit[31:16],
  // clear_error[32], stop_request[33], zero pad[39:34]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ucfp_pkg::OUT_DATA_W-1:0] out_tdata,
  // result tuser: frame_status[1:0]
  output logic [1:0]                      out_tuser,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ucfp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]                      cfg_data
);
  import ucfp_pkg::*;

  logic [BYTE_W-1:0] header_r, tail_r;
  logic              in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [CMD_W-1:0]  speed_r, speed_nxt;
  logic [CMD_W-1:0]  power_r, power_nxt;
  logic [BYTE_W-1:0] chk_r, chk_nxt;

  logic              out_valid_r;
  frame_status_t     status_r, status_nxt;
  logic [CMD_W-1:0]  out_speed_r, out_speed_nxt;
  logic [CMD_W-1:0]  out_power_r, out_power_nxt;
  logic              clear_r, clear_nxt;
  logic              stop_r, stop_nxt;

  logic              in_acc;
  logic              at_tail;
  logic              frame_done;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // position eight or beyond closes the frame
  assign at_tail    = in_frame_r && (pos_r > POS_CHECKSUM);
  assign frame_done = in_acc && at_tail;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      tail_r   <= TAIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_HEADER: header_r <= cfg_data;
        REG_TAIL:   tail_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame collection
  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    speed_nxt    = speed_r;
    power_nxt    = power_r;
    chk_nxt      = chk_r;
    if (in_acc) begin
      if (!in_frame_r) begin
        if (in_tdata == header_r) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = POS_W'(1);
          sum_nxt      = in_tdata;
        end
      end else if (at_tail) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        sum_nxt      = '0;
      end else if (pos_r == POS_CHECKSUM) begin
        chk_nxt = in_tdata;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        sum_nxt = sum_r + in_tdata;
        pos_nxt = pos_r + POS_W'(1);
        case (pos_r)
          POS_SPEED_HI: speed_nxt[15:8] = in_tdata;
          POS_SPEED_LO: speed_nxt[7:0]  = in_tdata;
          POS_POWER_HI: power_nxt[15:8] = in_tdata;
          POS_POWER_LO: power_nxt[7:0]  = in_tdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      sum_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    power_r <= power_nxt;
    chk_r   <= chk_nxt;
  end

  // status and result fields; tail checked before checksum
  always_comb begin
    if (in_tdata != tail_r)  status_nxt = ST_BAD_TAIL;
    else if (sum_r != chk_r) status_nxt = ST_BAD_SUM;
    else                     status_nxt = ST_GOOD;
    if (status_nxt == ST_GOOD) begin
      out_speed_nxt = speed_r;
      out_power_nxt = power_r;
      clear_nxt     = (speed_r != '0);
      stop_nxt      = (speed_r == '0);
    end else begin
      out_speed_nxt = '0;
      out_power_nxt = '0;
      clear_nxt     = 1'b0;
      stop_nxt      = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      status_r    <= status_nxt;
      out_speed_r <= out_speed_nxt;
      out_power_r <= out_power_nxt;
      clear_r     <= clear_nxt;
      stop_r      <= stop_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'b0, stop_r, clear_r, out_power_r, out_speed_r};

  // a tail byte taken always yields a result request next cycle
  a_tail_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> out_valid_r)
    else $error("tail byte accepted without a result");

  // bad frames carry zero payload
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_GOOD) |->
      (out_speed_r == '0 && out_power_r == '0 && !clear_r && !stop_r))
    else $error("bad frame with nonzero payload");

  // good frames ask for exactly one of clear and stop
  a_good_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_GOOD) |-> (clear_r ^ stop_r))
    else $error("good frame with inconsistent clear/stop");

  // hunting keeps the position at zero
  a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (pos_r == '0))
    else $error("position nonzero while hunting");

endmodule
